// ===== hdl/knnsv_pkg.sv =====
package knnsv_pkg;

    // Fixed field widths
    localparam int IDX_W     = 16;
    localparam int LABEL_W   = 16;
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;

    // Parameter defaults
    localparam int MAX_TRAIN_DEF = 65536;
    localparam int FRAC_BITS_DEF = 30;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_TRAIN     = 1'b0,
        REG_NUM_NEIGHBORS = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_ACC
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;    // capture input beat, set up divisor
        logic step;    // one restoring-division step
        logic commit;  // form value, update state, fill output register
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic div_last;  // current step is the final quotient bit
        logic out_free;  // output register can take a result
    } sts_t;

endpackage

// ===== hdl/knnsv_if.sv =====
interface knnsv_in_if;
    logic                            valid;
    logic                            ready;
    logic [knnsv_pkg::IDX_W-1:0]     train_index;
    logic [knnsv_pkg::LABEL_W-1:0]   train_label;
    logic [knnsv_pkg::LABEL_W-1:0]   test_label;

    modport source (output valid, output train_index, output train_label,
                    output test_label, input ready);
    modport sink   (input valid, input train_index, input train_label,
                    input test_label, output ready);
endinterface

interface knnsv_out_if;
    logic                               valid;
    logic                               ready;
    logic [knnsv_pkg::IDX_W-1:0]        point_index;
    logic signed [knnsv_pkg::VAL_W-1:0] shapley_value;
    logic                               last_of_test;

    modport source (output valid, output point_index, output shapley_value,
                    output last_of_test, input ready);
    modport sink   (input valid, input point_index, input shapley_value,
                    input last_of_test, output ready);
endinterface

// ===== hdl/knnsv_ctrl.sv =====
module knnsv_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  knnsv_pkg::sts_t   sts,
    output knnsv_pkg::cmd_t   cmd
);

    knnsv_pkg::state_t state_reg;
    knnsv_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= knnsv_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            knnsv_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = knnsv_pkg::S_DIV;
                end
            end
            knnsv_pkg::S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = knnsv_pkg::S_ACC;
                end
            end
            knnsv_pkg::S_ACC:
            begin
                if (sts.out_free)
                begin
                    state_next = knnsv_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = knnsv_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            knnsv_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            knnsv_pkg::S_DIV:
            begin
                cmd.step = 1'b1;
            end
            knnsv_pkg::S_ACC:
            begin
                cmd.commit = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/knnsv_dp.sv =====
module knnsv_dp
#(
    parameter int MAX_TRAIN = knnsv_pkg::MAX_TRAIN_DEF,
    parameter int FRAC_BITS = knnsv_pkg::FRAC_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  knnsv_pkg::cmd_t                     cmd,
    output knnsv_pkg::sts_t                     sts,
    input  logic                                cfg_we,
    input  logic [knnsv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [knnsv_pkg::CFG_W-1:0]         cfg_data,
    input  logic [knnsv_pkg::IDX_W-1:0]         train_index,
    input  logic [knnsv_pkg::LABEL_W-1:0]       train_label,
    input  logic [knnsv_pkg::LABEL_W-1:0]       test_label,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [knnsv_pkg::IDX_W-1:0]         point_index,
    output logic signed [knnsv_pkg::VAL_W-1:0]  shapley_value,
    output logic                                last_of_test
);

    localparam int CFG_W  = knnsv_pkg::CFG_W;
    localparam int VAL_W  = knnsv_pkg::VAL_W;
    localparam int RANK_W = $clog2(MAX_TRAIN);
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int STEP_W = $clog2(FRAC_BITS + 1);
    localparam int SUM_W  = VAL_W + 2;

    localparam logic signed [SUM_W-1:0] VAL_MAX = SUM_W'((64'sd1 <<< (VAL_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] VAL_MIN = -SUM_W'(64'sd1 <<< (VAL_W - 1));

    // Configuration
    logic [CFG_W-1:0] num_train_reg;
    logic [CFG_W-1:0] num_neighbors_reg;

    // Run state
    logic [RANK_W-1:0]       rank_count_reg;
    logic [RANK_W-1:0]       rank_count_next;
    logic signed [VAL_W-1:0] prev_value_reg;
    logic signed [VAL_W-1:0] prev_value_next;
    logic                    prev_match_reg;

    // Item being worked
    logic [RANK_W-1:0]       rank_reg;
    logic                    first_reg;
    logic                    match_reg;
    logic [knnsv_pkg::IDX_W-1:0] index_reg;

    // Divider
    logic [CFG_W-1:0]  div_d_reg;
    logic [CFG_W-1:0]  rem_reg;
    logic [CFG_W-1:0]  rem_next;
    logic [Q_W-1:0]    quo_reg;
    logic [Q_W-1:0]    quo_next;
    logic [STEP_W-1:0] step_reg;

    // Output register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [knnsv_pkg::IDX_W-1:0] out_index_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic                    out_last_reg;

    logic [CFG_W-1:0]  eff_n;
    logic [CFG_W-1:0]  eff_k;
    logic [CFG_W-1:0]  rank_p1;
    logic              first_now;
    logic [CFG_W-1:0]  divisor;
    logic [CFG_W:0]    trial;
    logic              dividend_bit;
    logic signed [SUM_W-1:0] q_ext;
    logic signed [SUM_W-1:0] sum;
    logic signed [VAL_W-1:0] value;
    logic              last_now;

    // N clamped to [2, MAX_TRAIN], K of zero acts as one
    always_comb
    begin
        if (num_train_reg < CFG_W'(2))
        begin
            eff_n = CFG_W'(2);
        end
        else if (num_train_reg > CFG_W'(MAX_TRAIN))
        begin
            eff_n = CFG_W'(MAX_TRAIN);
        end
        else
        begin
            eff_n = num_train_reg;
        end
        eff_k = (num_neighbors_reg == '0) ? CFG_W'(1) : num_neighbors_reg;
    end

    assign rank_p1   = CFG_W'(rank_count_reg) + CFG_W'(1);
    assign first_now = (CFG_W'(rank_count_reg) >= (eff_n - CFG_W'(1)));

    always_comb
    begin
        if (first_now)
        begin
            divisor = eff_n;
        end
        else if (eff_k > rank_p1)
        begin
            divisor = eff_k;
        end
        else
        begin
            divisor = rank_p1;
        end
    end

    // Restoring division of 2^FRAC_BITS, one quotient bit per step, MSB first
    assign dividend_bit = (step_reg == STEP_W'(FRAC_BITS));
    assign trial        = {rem_reg, dividend_bit};

    always_comb
    begin
        if (trial >= {1'b0, div_d_reg})
        begin
            rem_next = CFG_W'(trial - {1'b0, div_d_reg});
            quo_next = {quo_reg[Q_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[CFG_W-1:0];
            quo_next = {quo_reg[Q_W-2:0], 1'b0};
        end
    end

    // Accumulate and saturate
    assign q_ext = SUM_W'(quo_reg);

    always_comb
    begin
        if (match_reg && !prev_match_reg)
        begin
            sum = SUM_W'(prev_value_reg) + q_ext;
        end
        else if (!match_reg && prev_match_reg)
        begin
            sum = SUM_W'(prev_value_reg) - q_ext;
        end
        else
        begin
            sum = SUM_W'(prev_value_reg);
        end

        if (first_reg)
        begin
            value = match_reg ? VAL_W'(quo_reg) : '0;
        end
        else if (sum > VAL_MAX)
        begin
            value = VAL_MAX[VAL_W-1:0];
        end
        else if (sum < VAL_MIN)
        begin
            value = VAL_MIN[VAL_W-1:0];
        end
        else
        begin
            value = sum[VAL_W-1:0];
        end
    end

    assign last_now        = (rank_reg == '0);
    assign rank_count_next = last_now ? RANK_W'(eff_n - CFG_W'(1)) : rank_reg - RANK_W'(1);
    assign prev_value_next = value;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_train_reg     <= CFG_W'(2);
            num_neighbors_reg <= CFG_W'(1);
            rank_count_reg    <= RANK_W'(1);
            prev_value_reg    <= '0;
            prev_match_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
            step_reg          <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (knnsv_pkg::cfg_reg_t'(cfg_index))
                    knnsv_pkg::REG_NUM_TRAIN:
                    begin
                        num_train_reg  <= cfg_data;
                        // restart the run with the new N
                        if (cfg_data < CFG_W'(2))
                        begin
                            rank_count_reg <= RANK_W'(1);
                        end
                        else if (cfg_data > CFG_W'(MAX_TRAIN))
                        begin
                            rank_count_reg <= RANK_W'(MAX_TRAIN - 1);
                        end
                        else
                        begin
                            rank_count_reg <= RANK_W'(cfg_data - CFG_W'(1));
                        end
                        prev_value_reg <= '0;
                        prev_match_reg <= 1'b0;
                    end
                    knnsv_pkg::REG_NUM_NEIGHBORS:
                    begin
                        num_neighbors_reg <= cfg_data;
                    end
                    default:
                    begin
                        num_neighbors_reg <= num_neighbors_reg;
                    end
                endcase
            end
            else if (cmd.commit)
            begin
                rank_count_reg <= rank_count_next;
                prev_value_reg <= prev_value_next;
                prev_match_reg <= match_reg;
            end

            if (cmd.load)
            begin
                step_reg <= STEP_W'(FRAC_BITS);
            end
            else if (cmd.step && step_reg != '0)
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    assign out_valid_next = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            first_reg <= first_now;
            rank_reg  <= first_now ? RANK_W'(eff_n - CFG_W'(1)) : rank_count_reg;
            match_reg <= (train_label == test_label);
            index_reg <= train_index;
            div_d_reg <= divisor;
            rem_reg   <= '0;
            quo_reg   <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end

        if (cmd.commit)
        begin
            out_index_reg <= index_reg;
            out_value_reg <= value;
            out_last_reg  <= last_now;
        end
    end

    assign sts.div_last = (step_reg == '0);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign point_index   = out_index_reg;
    assign shapley_value = out_value_reg;
    assign last_of_test  = out_last_reg;

endmodule

// ===== hdl/knn_shapley_value_recursion.sv =====
// Channel  Dir  Beat fields                                   Handshake
// -------  ---  --------------------------------------------  -----------
// sample   in   train_index[16] train_label[16] test_label[16] valid/ready
// result   out  point_index[16] shapley_value[32s] last_of_test valid/ready
// cfg      in   cfg_index[1] cfg_data[17]                      cfg_we
//
// Per beat: take the beat, run the radix-2 restoring divider that forms
//   2^FRAC_BITS / divisor, then add, saturate and load the output register. A new
//   sample is taken only after the previous one has been committed.
// Reset: rst_n async low; N=2, K=1, rank counter at 1, previous value/match cleared.
// Stalls: a finished result waits in the output register while the next sample
//   is taken and divided; only the commit waits on result.ready.
module knn_shapley_value_recursion
#(
    parameter int MAX_TRAIN = knnsv_pkg::MAX_TRAIN_DEF,
    parameter int FRAC_BITS = knnsv_pkg::FRAC_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [knnsv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [knnsv_pkg::CFG_W-1:0]      cfg_data,
    knnsv_in_if.sink                         sample,
    knnsv_out_if.source                      result
);

    knnsv_pkg::cmd_t cmd;
    knnsv_pkg::sts_t sts;

    // Sequencer: take beat, step divider, commit when output slot is free
    knnsv_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Config registers, rank counter, previous value/match, divider, output register
    knnsv_dp
    #(
        .MAX_TRAIN (MAX_TRAIN),
        .FRAC_BITS (FRAC_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .train_index   (sample.train_index),
        .train_label   (sample.train_label),
        .test_label    (sample.test_label),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .point_index   (result.point_index),
        .shapley_value (result.shapley_value),
        .last_of_test  (result.last_of_test)
    );

endmodule
